// ----- rtl/core/phrtc_pkg.sv -----
// Shared types, constants and a helper function for the phantom RTC ROM socket.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none

package phrtc_pkg;

  localparam int unsigned PatternBits = 64;
  localparam int unsigned CountBits   = $clog2(PatternBits);

  localparam logic [PatternBits-1:0] UNLOCK_PATTERN = 64'h5CA3_3AC5_5CA3_3AC5;
  localparam logic [7:0]             HOUR_FLAG      = 8'h80;
  localparam logic [7:0]             DATA_KEEP_MASK = 8'hFE;
  localparam logic [2:0]             WEEKDAY_SUNDAY = 3'd7;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_MATCHING = 2'd1,
    MODE_READING  = 2'd2
  } mode_t;

  // One ROM read as seen on the socket, together with the current time.
  typedef struct packed {
    logic       data_bit;
    logic       read_mode;
    logic [7:0] rom_data;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [2:0] weekday;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [6:0] year_in_century;
  } item_t;

  // The byte returned to the CPU for that read.
  typedef struct packed {
    logic [7:0] read_data;
    logic       clock_bit_served;
  } result_t;

  // Engine state exported to the top level for checking.
  typedef struct packed {
    mode_t                mode;
    logic [CountBits-1:0] bit_count;
  } engine_status_t;

  // Tens digit in the high nibble, units in the low nibble. The division by
  // ten is a multiply by 205 and a shift, which is exact for all 7-bit values.
  function automatic logic [7:0] bcd_byte(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = {8'd0, v} * 15'd205;
    tens  = prod[14:11];
    units = v - 7'({3'd0, tens} * 7'd10);
    return {tens, units[3:0]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/phrtc_snapshot.sv -----
// Converts the current time fields of a word into the 64-bit BCD time image.
// Depends on phrtc_pkg.
`default_nettype none

module phrtc_snapshot (
  input  phrtc_pkg::item_t                          item,
  output logic [phrtc_pkg::PatternBits-1:0]         image
);
  import phrtc_pkg::*;

  logic [2:0] weekday_adj;

  // Sunday is reported as seven rather than zero.
  assign weekday_adj = (item.weekday == 3'd0) ? WEEKDAY_SUNDAY : item.weekday;

  assign image = {
    bcd_byte(item.year_in_century),
    bcd_byte({3'd0, item.month}),
    bcd_byte({2'd0, item.day_of_month}),
    {5'd0, weekday_adj},
    HOUR_FLAG | bcd_byte({2'd0, item.hours}),
    bcd_byte({1'd0, item.minutes}),
    bcd_byte({1'd0, item.seconds}),
    8'h00
  };

endmodule

`default_nettype wire

// ----- rtl/core/phrtc_engine.sv -----
// Mode sequencer, pattern shift register and time image for the ROM socket.
// Depends on phrtc_pkg and phrtc_snapshot.
`default_nettype none

module phrtc_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  phrtc_pkg::item_t           item,
  output phrtc_pkg::result_t         result,
  output phrtc_pkg::engine_status_t  status
);
  import phrtc_pkg::*;

  mode_t                  mode;
  mode_t                  mode_next;
  logic [CountBits-1:0]   bit_count;
  logic [CountBits-1:0]   bit_count_next;
  logic [PatternBits-1:0] pattern_shift;
  logic [PatternBits-1:0] pattern_shift_next;
  logic [PatternBits-1:0] time_snapshot;
  logic [PatternBits-1:0] snap_image;
  logic [PatternBits-1:0] pattern_full;
  logic [PatternBits-1:0] bit_mask;
  logic                   last_bit;
  logic                   unlocked;
  logic                   load_snapshot;

  phrtc_snapshot u_snapshot (
    .item  (item),
    .image (snap_image)
  );

  assign bit_mask     = {{(PatternBits-1){1'b0}}, item.data_bit} << bit_count;
  assign pattern_full = pattern_shift | bit_mask;
  assign last_bit     = (bit_count == CountBits'(PatternBits - 1));
  assign unlocked     = (pattern_full == UNLOCK_PATTERN);

  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_MATCHING: begin
        if (item.read_mode) begin
          mode_next = MODE_IDLE;
        end else if (last_bit) begin
          mode_next = unlocked ? MODE_READING : MODE_IDLE;
        end
      end
      MODE_READING: begin
        if (!item.read_mode) begin
          mode_next = MODE_MATCHING;
        end else if (last_bit) begin
          mode_next = MODE_IDLE;
        end
      end
      default: begin
        mode_next = item.read_mode ? MODE_IDLE : MODE_MATCHING;
      end
    endcase
  end

  always_comb begin
    result.read_data        = item.rom_data;
    result.clock_bit_served = 1'b0;
    bit_count_next          = bit_count;
    pattern_shift_next      = pattern_shift;
    load_snapshot           = 1'b0;
    unique case (mode)
      MODE_MATCHING: begin
        if (item.read_mode) begin
          bit_count_next = '0;
        end else begin
          // The counter wraps to zero on the last pattern bit.
          pattern_shift_next = pattern_full;
          bit_count_next     = bit_count + 1'b1;
          load_snapshot      = last_bit && unlocked;
        end
      end
      MODE_READING: begin
        if (item.read_mode) begin
          result.read_data        = (item.rom_data & DATA_KEEP_MASK)
                                    | {7'd0, time_snapshot[bit_count]};
          result.clock_bit_served = 1'b1;
          bit_count_next          = bit_count + 1'b1;
        end else begin
          pattern_shift_next = {{(PatternBits-1){1'b0}}, item.data_bit};
          bit_count_next     = CountBits'(1);
        end
      end
      default: begin
        if (!item.read_mode) begin
          pattern_shift_next = {{(PatternBits-1){1'b0}}, item.data_bit};
          bit_count_next     = CountBits'(1);
        end else begin
          bit_count_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      bit_count     <= '0;
      pattern_shift <= '0;
    end else if (step) begin
      mode          <= mode_next;
      bit_count     <= bit_count_next;
      pattern_shift <= pattern_shift_next;
    end
  end

  // The time image is only read after it has been loaded, so it needs no reset.
  always_ff @(posedge clk) begin
    if (step && load_snapshot) begin
      time_snapshot <= snap_image;
    end
  end

  assign status.mode      = mode;
  assign status.bit_count = bit_count;

endmodule

`default_nettype wire

// ----- rtl/core/phantom_rtc_rom_socket_core.sv -----
// Top level of the phantom RTC ROM socket: input register, engine, result register.
// Depends on phrtc_pkg, phrtc_engine and phrtc_snapshot.
//
// Every ROM read enters on the item channel (item_valid / item_ready / item)
// as one word carrying the address bits, the ROM byte and the current time.
// Each accepted word produces exactly one word on the result channel
// (result_valid / result_ready / result): the ROM byte, with bit 0 replaced
// by a time bit while the time image is being read out.
//
// A word is captured in the input register at the edge it is accepted; its
// result then passes into the result register. One word is taken per clock
// cycle; the figure is set by the input register and the result register,
// which both move together whenever the result register is free or being
// emptied in the same cycle.
//
// If the receiver holds result_ready low, the result register keeps its
// word, the input register fills, and item_ready falls until the receiver
// takes the result. Reset (rst, synchronous) empties both registers and
// returns the sequencer to idle with the pattern register cleared.
`default_nettype none

module phantom_rtc_rom_socket_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  phrtc_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_ready,
  output phrtc_pkg::result_t  result
);
  import phrtc_pkg::*;

  item_t          item_q;
  logic           item_q_valid;
  logic           advance;
  result_t        result_next;
  engine_status_t status;

  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  phrtc_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item_q),
    .result (result_next),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // The upper seven bits of the ROM byte always pass through untouched.
  assert property (@(posedge clk) disable iff (rst)
    advance |-> (result_next.read_data[7:1] == item_q.rom_data[7:1]))
    else $error("upper ROM data bits altered");

  // Bit 0 is only replaced while the time image is being read out.
  assert property (@(posedge clk) disable iff (rst)
    (advance && !result_next.clock_bit_served)
      |-> (result_next.read_data == item_q.rom_data))
    else $error("ROM byte altered without a time bit");

  assert property (@(posedge clk) disable iff (rst)
    (advance && result_next.clock_bit_served) |-> (status.mode == MODE_READING))
    else $error("time bit served outside the reading mode");

  // A data read during matching always aborts the sequence.
  assert property (@(posedge clk) disable iff (rst)
    (advance && status.mode == MODE_MATCHING && item_q.read_mode)
      |=> (status.mode == MODE_IDLE && status.bit_count == '0))
    else $error("data read did not abort matching");

  assert property (@(posedge clk) disable iff (rst)
    (status.mode == MODE_IDLE) |-> (status.bit_count == '0))
    else $error("bit counter not cleared in idle");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for phantom_rtc_rom_socket_core: ROM reads in, bytes to the CPU out.
// Needs phrtc_pkg for the word types, the unlock pattern and the mode codes.
// Directed script first, then random unlock attempts, read-outs and noise.
`timescale 1ns / 1ps

module testbench;
  import phrtc_pkg::*;

  typedef enum int {ROW_READ, ROW_UNLOCK} row_kind_t;

  // An unlock row sends the 64 pattern bits with its own byte and time fields.
  typedef struct {
    row_kind_t kind;
    int        reps;
    item_t     word;
    bit        pinned;
    result_t   want;
  } row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // Own copy of the sequencer state.
  mode_t       clock_mode = MODE_IDLE;
  logic [6:0]  bits_done = '0;
  logic [63:0] pattern_seen = '0;
  logic [63:0] time_image = '0;

  result_t expected_reads[$];
  int      words_sent = 0;
  int      results_seen = 0;
  int      faults = 0;
  int      send_idle_pct = 33;
  int      take_idle_pct = 33;
  int      hold_left = 0;
  bit      held = 1'b0;

  //        fields: data_bit, read_mode, rom_data, sec, min, hour, wday, day, month, year
  row_t script [13] = '{
    // Idle data reads pass the ROM byte unchanged.
    '{ROW_READ, 1, '{1'b0, 1'b1, 8'hFF, 6'd0, 6'd0, 5'd0, 3'd0, 5'd0, 4'd0, 7'd0},
      1'b1, '{8'hFF, 1'b0}},
    '{ROW_READ, 1, '{1'b0, 1'b1, 8'h00, 6'd0, 6'd0, 5'd0, 3'd0, 5'd0, 4'd0, 7'd0},
      1'b1, '{8'h00, 1'b0}},
    // A pattern bit starts matching, a data read then drops back to idle.
    '{ROW_READ, 1, '{1'b1, 1'b0, 8'hA5, 6'd0, 6'd0, 5'd0, 3'd0, 5'd0, 4'd0, 7'd0},
      1'b1, '{8'hA5, 1'b0}},
    '{ROW_READ, 1, '{1'b0, 1'b1, 8'h5A, 6'd0, 6'd0, 5'd0, 3'd0, 5'd0, 4'd0, 7'd0},
      1'b1, '{8'h5A, 1'b0}},
    // Largest legal time on a Sunday, read out in full and one read beyond.
    '{ROW_UNLOCK, 1, '{1'b0, 1'b0, 8'h3C, 6'd59, 6'd59, 5'd23, 3'd0, 5'd31, 4'd12, 7'd99},
      1'b0, '0},
    '{ROW_READ, 64, '{1'b0, 1'b1, 8'hFF, 6'd0, 6'd0, 5'd0, 3'd0, 5'd0, 4'd0, 7'd0},
      1'b0, '0},
    '{ROW_READ, 1, '{1'b0, 1'b1, 8'h81, 6'd0, 6'd0, 5'd0, 3'd0, 5'd0, 4'd0, 7'd0},
      1'b1, '{8'h81, 1'b0}},
    // Out-of-range time, a short read-out, then a pattern bit restarts matching.
    '{ROW_UNLOCK, 1, '{1'b0, 1'b0, 8'hC3, 6'd63, 6'd63, 5'd31, 3'd7, 5'd0, 4'd15, 7'd127},
      1'b0, '0},
    '{ROW_READ, 3, '{1'b0, 1'b1, 8'h00, 6'd0, 6'd0, 5'd0, 3'd0, 5'd0, 4'd0, 7'd0},
      1'b0, '0},
    '{ROW_READ, 1, '{1'b1, 1'b0, 8'h7E, 6'd0, 6'd0, 5'd0, 3'd0, 5'd0, 4'd0, 7'd0},
      1'b1, '{8'h7E, 1'b0}},
    '{ROW_READ, 1, '{1'b0, 1'b1, 8'hE7, 6'd0, 6'd0, 5'd0, 3'd0, 5'd0, 4'd0, 7'd0},
      1'b1, '{8'hE7, 1'b0}},
    // Smallest legal time, read out in full.
    '{ROW_UNLOCK, 1, '{1'b0, 1'b0, 8'h00, 6'd0, 6'd0, 5'd0, 3'd1, 5'd1, 4'd1, 7'd0},
      1'b0, '0},
    '{ROW_READ, 64, '{1'b0, 1'b1, 8'h00, 6'd0, 6'd0, 5'd0, 3'd0, 5'd0, 4'd0, 7'd0},
      1'b0, '0}
  };

  phantom_rtc_rom_socket_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [7:0] to_bcd(input int unsigned v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  // Works out the byte the CPU should see for one read and moves the state on.
  function automatic result_t predict_read(input item_t w);
    result_t    r;
    logic [7:0] day;
    r.read_data        = w.rom_data;
    r.clock_bit_served = 1'b0;
    case (clock_mode)
      MODE_MATCHING: begin
        if (!w.read_mode) begin
          pattern_seen = pattern_seen | (64'(w.data_bit) << bits_done[5:0]);
          bits_done    = bits_done + 7'd1;
          if (bits_done >= 7'd64) begin
            if (pattern_seen == UNLOCK_PATTERN) begin
              day = (w.weekday == 3'd0) ? {5'd0, WEEKDAY_SUNDAY} : {5'd0, w.weekday};
              time_image = {to_bcd(w.year_in_century), to_bcd(w.month),
                            to_bcd(w.day_of_month), day, HOUR_FLAG | to_bcd(w.hours),
                            to_bcd(w.minutes), to_bcd(w.seconds), 8'h00};
              clock_mode = MODE_READING;
            end else begin
              clock_mode = MODE_IDLE;
            end
            bits_done = '0;
          end
        end else begin
          clock_mode = MODE_IDLE;
          bits_done  = '0;
        end
      end
      MODE_READING: begin
        if (w.read_mode) begin
          r.read_data        = (w.rom_data & DATA_KEEP_MASK) | {7'd0, time_image[bits_done[5:0]]};
          r.clock_bit_served = 1'b1;
          bits_done          = bits_done + 7'd1;
          if (bits_done >= 7'd64) begin
            clock_mode = MODE_IDLE;
            bits_done  = '0;
          end
        end else begin
          clock_mode   = MODE_MATCHING;
          pattern_seen = {63'd0, w.data_bit};
          bits_done    = 7'd1;
        end
      end
      default: begin
        clock_mode = MODE_IDLE;
        if (!w.read_mode) begin
          clock_mode   = MODE_MATCHING;
          pattern_seen = {63'd0, w.data_bit};
          bits_done    = 7'd1;
        end
      end
    endcase
    return r;
  endfunction

  // A read with random ROM byte and time; now and then the time fields use their full width.
  function automatic item_t any_read(input bit read_mode, input bit data_bit);
    item_t w;
    bit    wild;
    wild              = roll(20);
    w.data_bit        = data_bit;
    w.read_mode       = read_mode;
    w.rom_data        = 8'($urandom);
    w.seconds         = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
    w.minutes         = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
    w.hours           = wild ? 5'($urandom) : 5'($urandom_range(0, 23));
    w.weekday         = wild ? 3'($urandom) : 3'($urandom_range(0, 6));
    w.day_of_month    = wild ? 5'($urandom) : 5'($urandom_range(1, 31));
    w.month           = wild ? 4'($urandom) : 4'($urandom_range(1, 12));
    w.year_in_century = wild ? 7'($urandom) : 7'($urandom_range(0, 99));
    return w;
  endfunction

  // Offers one word, possibly after a gap, and records what it should produce once taken.
  task automatic offer_read(input item_t w, input bit pinned, input result_t want);
    result_t predicted;
    if (roll(send_idle_pct)) begin
      item_valid <= 1'b0;
      do @(posedge clk); while (roll(send_idle_pct));
    end
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predicted = predict_read(w);
    expected_reads.push_back(pinned ? want : predicted);
    words_sent++;
  endtask

  // Result side: check at the edge, then choose ready for the next cycle.
  always @(posedge clk) begin
    result_t want;
    if (result_valid && result_ready) begin
      if (expected_reads.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected word: data %02h served %0b", result.read_data,
                   result.clock_bit_served);
      end else begin
        want = expected_reads.pop_front();
        if (result.read_data !== want.read_data ||
            result.clock_bit_served !== want.clock_bit_served) begin
          faults++;
          if (faults <= 10)
            $display("word %0d: expected data %02h served %0b, got data %02h served %0b",
                     results_seen, want.read_data, want.clock_bit_served,
                     result.read_data, result.clock_bit_served);
        end
      end
      results_seen++;
    end
    // One long hold-off in the random part, so that the block backs up to its input.
    if (results_seen == 420 && !held) begin
      held      = 1'b1;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= !roll(take_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("[phantom_rtc_rom_socket_core] ERROR");
    $finish;
  end

  initial begin
    item_t w;
    int    script_words;
    int    flip;
    int    cut;
    int    reads;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[r]) begin
      if (script[r].kind == ROW_UNLOCK) begin
        for (int i = 0; i < PatternBits; i++) begin
          w           = script[r].word;
          w.read_mode = 1'b0;
          w.data_bit  = UNLOCK_PATTERN[i];
          offer_read(w, 1'b0, '0);
        end
      end else begin
        repeat (script[r].reps) offer_read(script[r].word, script[r].pinned, script[r].want);
      end
    end

    script_words = words_sent;
    while (words_sent < 500) begin
      // The first stretch of the random part runs with neither side idling.
      send_idle_pct = (words_sent < script_words + 80) ? 0 : 33;
      take_idle_pct = send_idle_pct;
      if ($urandom_range(0, 99) < 70) begin
        // Unlock attempt, sometimes with a flipped bit or cut short by a data read.
        flip = roll(20) ? $urandom_range(0, 63) : -1;
        cut  = roll(10) ? $urandom_range(1, 63) : -1;
        for (int i = 0; i < PatternBits; i++) begin
          if (i == cut)
            offer_read(any_read(1'b1, 1'($urandom)), 1'b0, '0);
          offer_read(any_read(1'b0, UNLOCK_PATTERN[i] ^ (i == flip)), 1'b0, '0);
        end
        reads = roll(75) ? 64 : $urandom_range(0, 70);
        repeat (reads) offer_read(any_read(1'b1, 1'($urandom)), 1'b0, '0);
        if (roll(30))
          offer_read(any_read(1'b0, 1'($urandom)), 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 12))
          offer_read(any_read(1'($urandom), 1'($urandom)), 1'b0, '0);
      end
    end
    send_idle_pct = 33;
    take_idle_pct = 33;

    item_valid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (faults == 0) begin
      $display("[phantom_rtc_rom_socket_core] OK");
    end else begin
      $display("[phantom_rtc_rom_socket_core] ERROR");
    end
    $finish;
  end

endmodule
